// ----- src/bctc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bctc_pkg
// Types, codes and sizes shared by the buffer cache tag controller.
// ----------------------------------------------------------------------------
package bctc_pkg;

    localparam int SLOTS  = 16;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int REFS_W = 8;

    typedef enum logic [2:0] {
        K_ACQUIRE    = 3'd0,
        K_RELEASE    = 3'd1,
        K_REL_DIRTY  = 3'd2,
        K_WRITE_REL  = 3'd3,
        K_FLUSH      = 3'd4,
        K_INVALIDATE = 3'd5,
        K_SPARE6     = 3'd6,
        K_SPARE7     = 3'd7
    } t_kind;

    typedef enum logic [1:0] {
        CMD_DONE  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_WRITE = 2'd2
    } t_disk_cmd;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_RANGE  = 2'd1,
        ST_NOSLOT = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        CO_NONE,
        CO_HIT,
        CO_FILL,
        CO_RELEASE,
        CO_REL_DIRTY,
        CO_WRITE_REL,
        CO_CLEAN,
        CO_INVAL
    } t_cell_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOOKUP,
        S_VSCAN,
        S_FILL,
        S_RELEASE,
        S_FLUSH,
        S_INVAL,
        S_DONE
    } t_state;

    // Broadcast from the sequencer to every cell.
    typedef struct packed {
        t_cell_op              op;
        logic [SLOT_W-1:0]     sel;
        logic [SLOT_W-1:0]     sel_rank;
        logic [SLOT_W-1:0]     scan_rank;
        logic [7:0]            device;
        logic [23:0]           block;
    } t_cell_cmd;

    // Passed from cell to cell: lowest matching tag and the slot of a rank.
    typedef struct packed {
        logic                  m_found;
        logic [SLOT_W-1:0]     m_idx;
        logic                  r_found;
        logic [SLOT_W-1:0]     r_idx;
    } t_chain;

    typedef struct packed {
        logic                  occupied;
        logic                  valid;
        logic                  dirty;
        logic                  busy;
        logic                  refs_zero;
        logic [23:0]           block;
        logic [SLOT_W-1:0]     rank;
    } t_cell_stat;

endpackage

// ----- src/bctc_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bctc_cell
// One cache slot: tag, marks, reference count and recency rank.
// ----------------------------------------------------------------------------
module bctc_cell import bctc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [SLOT_W-1:0] i_idx,
    input  t_cell_cmd         i_cmd,
    input  t_chain            i_chain,
    output t_chain            o_chain,
    output t_cell_stat        o_stat
);

    logic              r_occupied, r_valid, r_dirty, r_busy;
    logic [7:0]        r_device;
    logic [23:0]       r_block;
    logic [REFS_W-1:0] r_refs;
    logic [SLOT_W-1:0] r_rank;

    logic sel, match, rank_hit, refs_zero;
    logic [REFS_W-1:0] refs_dec;

    assign sel       = (i_cmd.sel == i_idx);
    assign refs_zero = (r_refs == '0);
    assign refs_dec  = refs_zero ? r_refs : r_refs - REFS_W'(1);
    assign match     = r_occupied && (r_device == i_cmd.device) && (r_block == i_cmd.block);
    assign rank_hit  = (r_rank == i_cmd.scan_rank);

    always_comb begin
        o_chain = i_chain;
        if (!i_chain.m_found && match) begin
            o_chain.m_found = 1'b1;
            o_chain.m_idx   = i_idx;
        end
        if (!i_chain.r_found && rank_hit) begin
            o_chain.r_found = 1'b1;
            o_chain.r_idx   = i_idx;
        end
    end

    assign o_stat = '{occupied: r_occupied, valid: r_valid, dirty: r_dirty, busy: r_busy,
                      refs_zero: refs_zero, block: r_block, rank: r_rank};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occupied <= 1'b0;
            r_valid    <= 1'b0;
            r_dirty    <= 1'b0;
            r_busy     <= 1'b0;
            r_refs     <= '0;
            r_rank     <= i_idx;
            r_device   <= '0;
            r_block    <= '0;
        end else begin
            // A hit or fill moves the target to the top; those above it drop one.
            if (i_cmd.op == CO_HIT || i_cmd.op == CO_FILL) begin
                if (sel) begin
                    r_rank <= SLOT_W'(SLOTS - 1);
                end else if (r_rank > i_cmd.sel_rank) begin
                    r_rank <= r_rank - SLOT_W'(1);
                end
            end
            case (i_cmd.op)
                CO_HIT: begin
                    if (sel) begin
                        r_valid <= 1'b1;
                        r_busy  <= 1'b1;
                        if (r_refs != '1) r_refs <= r_refs + REFS_W'(1);
                    end
                end
                CO_FILL: begin
                    if (sel) begin
                        r_occupied <= 1'b1;
                        r_device   <= i_cmd.device;
                        r_block    <= i_cmd.block;
                        r_dirty    <= 1'b0;
                        r_valid    <= 1'b1;
                        r_busy     <= 1'b1;
                        r_refs     <= REFS_W'(1);
                    end
                end
                CO_RELEASE, CO_REL_DIRTY, CO_WRITE_REL: begin
                    if (sel) begin
                        if (i_cmd.op == CO_REL_DIRTY) r_dirty <= 1'b1;
                        if (i_cmd.op == CO_WRITE_REL) begin
                            r_dirty <= 1'b0;
                            r_valid <= 1'b1;
                        end
                        r_refs <= refs_dec;
                        if (r_refs == REFS_W'(1)) r_busy <= 1'b0;
                    end
                end
                CO_CLEAN: begin
                    if (sel) r_dirty <= 1'b0;
                end
                CO_INVAL: begin
                    if (refs_zero && !r_busy) r_valid <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// ----- src/block_cache_tag_controller_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_cache_tag_controller_unit
// Tag and replacement controller of a block buffer cache, built as a row of
// slot cells under a small sequencer.
// ----------------------------------------------------------------------------
//  channel  | signals                                        | transfer
//  request  | start, busy, i_kind, i_device, i_block_number, | start && !busy
//           | i_handle                                       |
//  result   | o_valid, o_command, o_disk_block, o_slot_index,| o_valid (one cycle)
//           | o_status, o_last                               |
//  config   | i_cfg_valid, o_cfg_ready, i_cfg_data           | valid && ready
//
// An acquire hit goes through S_LOOKUP and S_DONE; a miss walks the recency ranks
// one per cycle, then fills the chosen slot or ends with no slot free. Flush walks all
// slots one per cycle, and invalidate adds an S_INVAL step. Releases pass S_RELEASE.
// Reset sets every cell at once; no clearing pass is needed.
// Results cannot be stalled; busy stays high until the done transfer is shown.
// ----------------------------------------------------------------------------
module block_cache_tag_controller_unit import bctc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_kind,
    input  logic [7:0]  i_device,
    input  logic [23:0] i_block_number,
    input  logic [3:0]  i_handle,
    output logic        o_valid,
    output logic [1:0]  o_command,
    output logic [23:0] o_disk_block,
    output logic [3:0]  o_slot_index,
    output logic [1:0]  o_status,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [24:0] i_cfg_data
);

    t_state r_state, n_state;
    logic        r_busy, n_busy;
    logic [24:0] r_total;
    t_kind       r_kind;
    logic [7:0]  r_device;
    logic [23:0] r_block;
    logic [3:0]  r_handle;
    logic [SLOT_W-1:0] r_cnt, n_cnt, r_sel, n_sel;
    t_status     r_done_st, n_done_st;

    logic        r_out_valid, n_out_valid, r_out_last, n_out_last;
    t_disk_cmd   r_out_cmd, n_out_cmd;
    t_status     r_out_st, n_out_st;
    logic [23:0] r_out_blk, n_out_blk;
    logic [3:0]  r_out_slot, n_out_slot;

    t_cell_cmd   cmd;
    t_chain      chain [SLOTS+1];
    t_cell_stat  stat  [SLOTS];
    t_cell_stat  st_m, st_r, st_s;
    logic        accept, hok;

    assign accept      = start && !r_busy;
    assign busy        = r_busy;
    assign o_cfg_ready = 1'b1;
    assign hok         = 32'(r_handle) < SLOTS;

    assign chain[0] = '0;
    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        bctc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (SLOT_W'(g)),
            .i_cmd   (cmd),
            .i_chain (chain[g]),
            .o_chain (chain[g+1]),
            .o_stat  (stat[g])
        );
    end

    assign st_m = stat[chain[SLOTS].m_idx];
    assign st_r = stat[chain[SLOTS].r_idx];
    assign st_s = stat[r_sel];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_busy      <= 1'b0;
            r_total     <= 25'd16777216;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) r_total <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind   <= t_kind'(i_kind);
            r_device <= i_device;
            r_block  <= i_block_number;
            r_handle <= i_handle;
        end
        r_cnt      <= n_cnt;
        r_sel      <= n_sel;
        r_done_st  <= n_done_st;
        r_out_cmd  <= n_out_cmd;
        r_out_st   <= n_out_st;
        r_out_blk  <= n_out_blk;
        r_out_slot <= n_out_slot;
        r_out_last <= n_out_last;
    end

    always_comb begin
        n_state     = r_state;
        n_busy      = r_busy;
        n_cnt       = r_cnt;
        n_sel       = r_sel;
        n_done_st   = r_done_st;
        n_out_valid = 1'b0;
        n_out_cmd   = CMD_DONE;
        n_out_st    = ST_OK;
        n_out_blk   = '0;
        n_out_slot  = '0;
        n_out_last  = 1'b0;
        cmd.op        = CO_NONE;
        cmd.sel       = r_sel;
        cmd.sel_rank  = st_s.rank;
        cmd.scan_rank = r_cnt;
        cmd.device    = r_device;
        cmd.block     = r_block;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_busy    = 1'b1;
                    n_cnt     = '0;
                    n_sel     = '0;
                    n_done_st = ST_OK;
                    case (t_kind'(i_kind))
                        K_ACQUIRE:                          n_state = S_LOOKUP;
                        K_RELEASE, K_REL_DIRTY, K_WRITE_REL: n_state = S_RELEASE;
                        K_FLUSH, K_INVALIDATE:              n_state = S_FLUSH;
                        default:                            n_state = S_DONE;
                    endcase
                end
            end
            S_LOOKUP: begin
                if (25'(r_block) >= r_total) begin
                    n_done_st = ST_RANGE;
                    n_state   = S_DONE;
                end else if (chain[SLOTS].m_found) begin
                    n_sel        = chain[SLOTS].m_idx;
                    cmd.op       = CO_HIT;
                    cmd.sel      = chain[SLOTS].m_idx;
                    cmd.sel_rank = st_m.rank;
                    if (!st_m.valid) begin
                        n_out_valid = 1'b1;
                        n_out_cmd   = CMD_READ;
                        n_out_blk   = r_block;
                        n_out_slot  = 4'(chain[SLOTS].m_idx);
                    end
                    n_state = S_DONE;
                end else begin
                    n_state = S_VSCAN;
                end
            end
            S_VSCAN: begin
                // Ranks are a permutation, so exactly one cell answers each rank.
                if (st_r.refs_zero && !st_r.busy) begin
                    n_sel = chain[SLOTS].r_idx;
                    if (st_r.occupied && st_r.dirty) begin
                        n_out_valid = 1'b1;
                        n_out_cmd   = CMD_WRITE;
                        n_out_blk   = st_r.block;
                        n_out_slot  = 4'(chain[SLOTS].r_idx);
                    end
                    n_state = S_FILL;
                end else if (r_cnt == SLOT_W'(SLOTS - 1)) begin
                    n_done_st = ST_NOSLOT;
                    n_state   = S_DONE;
                end else begin
                    n_cnt = r_cnt + SLOT_W'(1);
                end
            end
            S_FILL: begin
                cmd.op      = CO_FILL;
                n_out_valid = 1'b1;
                n_out_cmd   = CMD_READ;
                n_out_blk   = r_block;
                n_out_slot  = 4'(r_sel);
                n_state     = S_DONE;
            end
            S_RELEASE: begin
                n_sel   = '0;
                cmd.sel = SLOT_W'(r_handle);
                if (hok) begin
                    case (r_kind)
                        K_RELEASE:   cmd.op = CO_RELEASE;
                        K_REL_DIRTY: cmd.op = CO_REL_DIRTY;
                        default: begin
                            cmd.op = CO_WRITE_REL;
                            if (stat[SLOT_W'(r_handle)].dirty) begin
                                n_out_valid = 1'b1;
                                n_out_cmd   = CMD_WRITE;
                                n_out_blk   = stat[SLOT_W'(r_handle)].block;
                                n_out_slot  = r_handle;
                            end
                        end
                    endcase
                end
                n_state = S_DONE;
            end
            S_FLUSH: begin
                cmd.sel = r_cnt;
                if (stat[r_cnt].occupied && stat[r_cnt].dirty && stat[r_cnt].refs_zero) begin
                    cmd.op      = CO_CLEAN;
                    n_out_valid = 1'b1;
                    n_out_cmd   = CMD_WRITE;
                    n_out_blk   = stat[r_cnt].block;
                    n_out_slot  = 4'(r_cnt);
                end
                if (r_cnt == SLOT_W'(SLOTS - 1)) begin
                    n_state = (r_kind == K_INVALIDATE) ? S_INVAL : S_DONE;
                end else begin
                    n_cnt = r_cnt + SLOT_W'(1);
                end
            end
            S_INVAL: begin
                cmd.op  = CO_INVAL;
                n_state = S_DONE;
            end
            S_DONE: begin
                n_out_valid = 1'b1;
                n_out_cmd   = CMD_DONE;
                n_out_st    = r_done_st;
                n_out_last  = 1'b1;
                // Only a granted acquire reports its slot on the done item.
                if (r_kind == K_ACQUIRE && r_done_st == ST_OK) n_out_slot = 4'(r_sel);
                n_busy  = 1'b0;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
                n_busy  = 1'b0;
            end
        endcase
    end

    assign o_valid      = r_out_valid;
    assign o_command    = r_out_cmd;
    assign o_disk_block = r_out_blk;
    assign o_slot_index = r_out_slot;
    assign o_status     = r_out_st;
    assign o_last       = r_out_last;

`ifndef SYNTHESIS
    a_result_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_busy))
        else $error("result shown with no operation in progress");
    a_last_only_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_command != CMD_DONE |-> !o_last && o_status == ST_OK)
        else $error("disk command marked as final or with a status");
    a_idle_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> !busy)
        else $error("still busy when the done transfer is shown");
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted request did not raise busy");
`endif

endmodule
